// ===== rtl/pfrwl_pkg.sv =====
// ----------------------------------------------------------------------------
// pfrwl_pkg
// Shared types, widths and codes of the phase-fair reader-writer lock manager.
// ----------------------------------------------------------------------------
package pfrwl_pkg;

  // number of agents that may take the lock; ids at or above are foreign
  localparam int NUM_REQUESTERS = 16;

  localparam int ID_W   = 4;
  localparam int MAP_W  = 1 << ID_W;
  localparam int QDEPTH = 16;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = QPTR_W + 1;
  localparam int RD_W   = 5;

  typedef enum logic [1:0] {
    CMD_RD_LOCK   = 2'd0,
    CMD_WR_LOCK   = 2'd1,
    CMD_RD_UNLOCK = 2'd2,
    CMD_WR_UNLOCK = 2'd3
  } cmd_t;

  typedef enum logic {
    BK_RUN  = 1'b0,
    BK_SCAN = 1'b1
  } bk_state_t;

  typedef struct packed {
    cmd_t            cmd;
    logic [ID_W-1:0] id;
  } op_t;

  // head of the command queue as seen by the back end
  typedef struct packed {
    logic valid;
    op_t  op;
  } q_head_t;

  // lock commands from ids outside the requester range are dropped
  function automatic logic is_foreign(input logic [ID_W-1:0] id);
    return (32'(id) >= 32'(NUM_REQUESTERS));
  endfunction

endpackage

// ===== rtl/pfrwl_if.sv =====
// ----------------------------------------------------------------------------
// pfrwl_if
// Valid/ready channels for lock commands and for grants.
// ----------------------------------------------------------------------------
interface pfrwl_in_if;
  import pfrwl_pkg::*;

  logic            valid;
  logic            ready;
  logic [1:0]      command;
  logic [ID_W-1:0] requester;

  modport source (output valid, output command, output requester, input ready);
  modport sink   (input valid, input command, input requester, output ready);
endinterface

interface pfrwl_out_if;
  import pfrwl_pkg::*;

  logic            valid;
  logic            ready;
  logic [ID_W-1:0] granted_requester;
  logic            granted_write;
  logic            last;

  modport source (output valid, output granted_requester, output granted_write,
                  output last, input ready);
  modport sink   (input valid, input granted_requester, input granted_write,
                  input last, output ready);
endinterface

// ===== rtl/phase_fair_rw_lock_manager.sv =====
// ----------------------------------------------------------------------------
// phase_fair_rw_lock_manager
// Phase-fair reader-writer lock manager with FIFO writer ordering.
//
// Lock and unlock commands enter through a two-entry command queue, so
// commands are taken while a grant waits at the output. The executor handles
// one queued command per cycle when the grant register is free: a lock or read
// unlock yields at most one grant. A write unlock that releases blocked readers
// is followed by one read grant per cycle while the grant register is free, in
// ascending id order, and holds further commands until the last of them is
// issued; the next queued writer is promoted at once but is granted only after
// those readers unlock. Up to sixteen writers may wait; a write lock beyond
// that is dropped. The last grant caused by a command carries last high.
// ----------------------------------------------------------------------------
module phase_fair_rw_lock_manager
  import pfrwl_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  pfrwl_in_if.sink     in_ch,
  pfrwl_out_if.source  out_ch
);

  q_head_t q_head;
  logic    q_pop;

  // command intake and queue
  pfrwl_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_head (q_head),
    .q_pop  (q_pop)
  );

  // lock state and grant sequencing
  pfrwl_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_head (q_head),
    .q_pop  (q_pop),
    .out_ch (out_ch)
  );

endmodule

// ===== rtl/pfrwl_front.sv =====
// ----------------------------------------------------------------------------
// pfrwl_front
// Takes commands, drops foreign lock requests and queues the rest (two deep).
// ----------------------------------------------------------------------------
module pfrwl_front
  import pfrwl_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  pfrwl_in_if.sink     in_ch,
  output q_head_t      q_head,
  input  logic         q_pop
);

  op_t        mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       in_xfer;
  logic       keep;
  logic       push;
  op_t        in_op;

  // classify the incoming command
  always_comb begin
    in_op.cmd = cmd_t'(in_ch.command);
    in_op.id  = in_ch.requester;
    keep      = !(((in_op.cmd == CMD_RD_LOCK) || (in_op.cmd == CMD_WR_LOCK)) &&
                  is_foreign(in_op.id));
  end

  assign in_ch.ready = (cnt_r != 2'd2);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign push        = in_xfer && keep;

  // queue pointers and fill level
  always_comb begin
    wr_ptr_nxt = push  ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_op;
    end
  end

  assign q_head.valid = (cnt_r != 2'd0);
  assign q_head.op    = mem_r[rd_ptr_r];

endmodule

// ===== rtl/pfrwl_back.sv =====
// ----------------------------------------------------------------------------
// pfrwl_back
// Executes queued lock commands, keeps the lock state and emits grants.
// ----------------------------------------------------------------------------
module pfrwl_back
  import pfrwl_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  q_head_t       q_head,
  output logic          q_pop,
  pfrwl_out_if.source   out_ch
);

  localparam logic [RD_W-1:0] RD_MAX = '1;

  bk_state_t         state_r, state_nxt;
  logic [RD_W-1:0]   rd_r, rd_nxt;
  logic              wp_r, wp_nxt;
  logic              wh_r, wh_nxt;
  logic [ID_W-1:0]   pwid_r, pwid_nxt;
  logic [MAP_W-1:0]  map_r, map_nxt;
  logic [MAP_W-1:0]  scan_r, scan_nxt;
  logic [QPTR_W-1:0] qhead_r, qhead_nxt;
  logic [QCNT_W-1:0] qcnt_r, qcnt_nxt;
  logic [ID_W-1:0]   queue_mem [QDEPTH];

  logic              out_valid_r, out_valid_nxt;
  logic [ID_W-1:0]   out_id_r, out_id_nxt;
  logic              out_wr_r, out_wr_nxt;
  logic              out_last_r, out_last_nxt;

  logic              can_emit;
  logic              qw_en;
  logic [QPTR_W-1:0] qw_addr;
  logic [ID_W-1:0]   q_front;
  logic [RD_W-1:0]   rd_inc;
  logic [RD_W-1:0]   rd_dec;
  logic [MAP_W-1:0]  lsb_onehot;
  logic [ID_W-1:0]   lsb_idx;
  logic [MAP_W-1:0]  scan_rest;

  assign can_emit = !out_valid_r || out_ch.ready;
  assign rd_inc   = (rd_r == RD_MAX) ? rd_r : rd_r + 1'b1;
  assign rd_dec   = (rd_r == '0) ? rd_r : rd_r - 1'b1;
  assign q_front  = queue_mem[qhead_r];
  assign qw_addr  = qhead_r + qcnt_r[QPTR_W-1:0];

  // lowest blocked reader still to be granted
  always_comb begin
    lsb_onehot = scan_r & (~scan_r + 1'b1);
    scan_rest  = scan_r & ~lsb_onehot;
    lsb_idx    = '0;
    for (int i = 0; i < MAP_W; i++) begin
      if (lsb_onehot[i]) begin
        lsb_idx = lsb_idx | ID_W'(i);
      end
    end
  end

  // command execution and grant sequencing
  always_comb begin
    state_nxt     = state_r;
    rd_nxt        = rd_r;
    wp_nxt        = wp_r;
    wh_nxt        = wh_r;
    pwid_nxt      = pwid_r;
    map_nxt       = map_r;
    scan_nxt      = scan_r;
    qhead_nxt     = qhead_r;
    qcnt_nxt      = qcnt_r;
    qw_en         = 1'b0;
    q_pop         = 1'b0;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_id_nxt    = out_id_r;
    out_wr_nxt    = out_wr_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      BK_RUN: begin
        if (q_head.valid && can_emit) begin
          q_pop = 1'b1;
          unique case (q_head.op.cmd)
            CMD_RD_LOCK: begin
              if (!wp_r) begin
                rd_nxt        = rd_inc;
                out_valid_nxt = 1'b1;
                out_id_nxt    = q_head.op.id;
                out_wr_nxt    = 1'b0;
                out_last_nxt  = 1'b1;
              end else begin
                map_nxt = map_r | (MAP_W'(1) << q_head.op.id);
              end
            end
            CMD_WR_LOCK: begin
              if (!wp_r) begin
                wp_nxt   = 1'b1;
                wh_nxt   = 1'b0;
                pwid_nxt = q_head.op.id;
                if (rd_r == '0) begin
                  wh_nxt        = 1'b1;
                  out_valid_nxt = 1'b1;
                  out_id_nxt    = q_head.op.id;
                  out_wr_nxt    = 1'b1;
                  out_last_nxt  = 1'b1;
                end
              end else if (qcnt_r < QCNT_W'(QDEPTH)) begin
                qw_en    = 1'b1;
                qcnt_nxt = qcnt_r + 1'b1;
              end
            end
            CMD_RD_UNLOCK: begin
              rd_nxt = rd_dec;
              if (wp_r && !wh_r && (rd_dec == '0)) begin
                wh_nxt        = 1'b1;
                out_valid_nxt = 1'b1;
                out_id_nxt    = pwid_r;
                out_wr_nxt    = 1'b1;
                out_last_nxt  = 1'b1;
              end
            end
            CMD_WR_UNLOCK: begin
              map_nxt  = '0;
              scan_nxt = map_r;
              wh_nxt   = 1'b0;
              if (qcnt_r != '0) begin
                wp_nxt    = 1'b1;
                pwid_nxt  = q_front;
                qhead_nxt = qhead_r + 1'b1;
                qcnt_nxt  = qcnt_r - 1'b1;
              end else begin
                wp_nxt = 1'b0;
              end
              if (map_r != '0) begin
                // readers released: the promoted writer waits for them
                state_nxt = BK_SCAN;
              end else if ((qcnt_r != '0) && (rd_r == '0)) begin
                wh_nxt        = 1'b1;
                out_valid_nxt = 1'b1;
                out_id_nxt    = q_front;
                out_wr_nxt    = 1'b1;
                out_last_nxt  = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      BK_SCAN: begin
        if (can_emit) begin
          rd_nxt        = rd_inc;
          scan_nxt      = scan_rest;
          out_valid_nxt = 1'b1;
          out_id_nxt    = lsb_idx;
          out_wr_nxt    = 1'b0;
          out_last_nxt  = (scan_rest == '0);
          if (scan_rest == '0) begin
            state_nxt = BK_RUN;
          end
        end
      end
      default: begin
        state_nxt = BK_RUN;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_RUN;
      rd_r        <= '0;
      wp_r        <= 1'b0;
      wh_r        <= 1'b0;
      pwid_r      <= '0;
      map_r       <= '0;
      scan_r      <= '0;
      qhead_r     <= '0;
      qcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_r        <= rd_nxt;
      wp_r        <= wp_nxt;
      wh_r        <= wh_nxt;
      pwid_r      <= pwid_nxt;
      map_r       <= map_nxt;
      scan_r      <= scan_nxt;
      qhead_r     <= qhead_nxt;
      qcnt_r      <= qcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // grant payload register
  always_ff @(posedge clk) begin
    out_id_r   <= out_id_nxt;
    out_wr_r   <= out_wr_nxt;
    out_last_r <= out_last_nxt;
  end

  // writer queue storage
  always_ff @(posedge clk) begin
    if (qw_en) begin
      queue_mem[qw_addr] <= q_head.op.id;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.granted_requester = out_id_r;
  assign out_ch.granted_write     = out_wr_r;
  assign out_ch.last              = out_last_r;

  // a reader scan always has readers left to grant
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_SCAN) |-> (scan_r != '0))
    else $error("reader scan with empty map");

  // a writer can hold the lock only while present
  assert property (@(posedge clk) disable iff (!rst_n)
    wh_r |-> wp_r)
    else $error("writer holding without being present");

  // a writer takes the lock only with no active readers
  assert property (@(posedge clk) disable iff (!rst_n)
    (wh_r && !$past(wh_r)) |-> (rd_r == '0))
    else $error("writer granted while readers active");

  // no new command is taken while readers are being released
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_SCAN) |=> ($past(scan_r) != '0) && !$past(q_pop))
    else $error("command taken during reader scan");

endmodule

// ===== tb/sv/phase_fair_rw_lock_manager_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// phase_fair_rw_lock_manager_tb
// Drives lock and unlock commands into the lock manager and checks every
// grant against a cycle-free model of the phase-fair lock. Covers reader
// saturation, blocked reader release, writer queue overflow and misuse,
// with random idle bursts on the command side and stalls on the grant side.
// ----------------------------------------------------------------------------
module phase_fair_rw_lock_manager_tb;
  import pfrwl_pkg::*;

  // predicts grants from accepted commands and checks delivered grants
  class lock_grant_tracker;
    typedef struct packed {
      logic [ID_W-1:0] requester;
      logic            is_write;
      logic            last;
    } grant_t;

    grant_t pending_grants[$];
    int     mismatches;

    bit [RD_W-1:0]   reader_count;
    bit              writer_present;
    bit              writer_holding;
    bit [ID_W-1:0]   present_writer;
    bit [MAP_W-1:0]  blocked_readers;
    bit [ID_W-1:0]   writer_fifo[QDEPTH];
    bit [QPTR_W-1:0] fifo_head;
    bit [QCNT_W-1:0] fifo_count;

    function new();
      mismatches      = 0;
      reader_count    = '0;
      writer_present  = 1'b0;
      writer_holding  = 1'b0;
      present_writer  = '0;
      blocked_readers = '0;
      fifo_head       = '0;
      fifo_count      = '0;
      foreach (writer_fifo[i]) writer_fifo[i] = '0;
    endfunction

    function void push_grant(input bit [ID_W-1:0] id, input bit wr);
      grant_t g;
      g.requester = id;
      g.is_write  = wr;
      g.last      = 1'b0;
      pending_grants.push_back(g);
    endfunction

    // present writer takes the lock once readers are gone
    function void grant_writer_if_free();
      if (writer_present && !writer_holding && reader_count == 0) begin
        writer_holding = 1'b1;
        push_grant(present_writer, 1'b1);
      end
    endfunction

    function void note_command(input cmd_t c, input logic [ID_W-1:0] id);
      int before_count;
      before_count = pending_grants.size();
      case (c)
        CMD_RD_LOCK: begin
          if (int'(id) < NUM_REQUESTERS) begin
            if (!writer_present) begin
              if (reader_count != '1) reader_count++;
              push_grant(id, 1'b0);
            end else begin
              blocked_readers[id] = 1'b1;
            end
          end
        end
        CMD_WR_LOCK: begin
          if (int'(id) < NUM_REQUESTERS) begin
            if (!writer_present) begin
              writer_present = 1'b1;
              writer_holding = 1'b0;
              present_writer = id;
              grant_writer_if_free();
            end else if (fifo_count < QDEPTH) begin
              writer_fifo[fifo_head + QPTR_W'(fifo_count)] = id;
              fifo_count++;
            end
          end
        end
        CMD_RD_UNLOCK: begin
          if (reader_count != 0) reader_count--;
          grant_writer_if_free();
        end
        default: begin
          // release every blocked reader as one read phase
          for (int i = 0; i < MAP_W && i < NUM_REQUESTERS; i++) begin
            if (blocked_readers[i]) begin
              if (reader_count != '1) reader_count++;
              push_grant(ID_W'(i), 1'b0);
            end
          end
          blocked_readers = '0;
          writer_holding  = 1'b0;
          if (fifo_count != 0) begin
            writer_present = 1'b1;
            present_writer = writer_fifo[fifo_head];
            fifo_head++;
            fifo_count--;
            grant_writer_if_free();
          end else begin
            writer_present = 1'b0;
          end
        end
      endcase
      if (pending_grants.size() > before_count)
        pending_grants[pending_grants.size()-1].last = 1'b1;
    endfunction

    function void check_grant(input logic [ID_W-1:0] id, input logic wr, input logic lst);
      grant_t exp_g;
      if (pending_grants.size() == 0) begin
        $error("unexpected grant: requester %0d, write %0d, last %0d", id, wr, lst);
        mismatches++;
        return;
      end
      exp_g = pending_grants.pop_front();
      if (id !== exp_g.requester) begin
        $error("granted_requester: expected %0d, actual %0d", exp_g.requester, id);
        mismatches++;
      end
      if (wr !== exp_g.is_write) begin
        $error("granted_write: expected %0d, actual %0d", exp_g.is_write, wr);
        mismatches++;
      end
      if (lst !== exp_g.last) begin
        $error("last: expected %0d, actual %0d", exp_g.last, lst);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  pfrwl_in_if  in_ch ();
  pfrwl_out_if out_ch ();

  phase_fair_rw_lock_manager dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  lock_grant_tracker tracker;
  int idle_pct;
  int stall_pct;
  int stall_left;
  bit quiet;
  int commands_sent;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // overall time limit
  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // grant side: check transfers and stall in bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready)
        tracker.check_grant(out_ch.granted_requester, out_ch.granted_write, out_ch.last);
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (!quiet && $urandom_range(99) < stall_pct) begin
        out_ch.ready <= 1'b0;
        stall_left = $urandom_range(5, 1) - 1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  function automatic logic [ID_W-1:0] any_id();
    return ID_W'($urandom_range(MAP_W - 1));
  endfunction

  // one command transfer, with an optional idle burst ahead of it
  task automatic send_command(input cmd_t c, input logic [ID_W-1:0] id);
    int gap;
    if (!quiet && $urandom_range(99) < idle_pct) begin
      gap = $urandom_range(5, 1);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.command   <= c;
    in_ch.requester <= id;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    tracker.note_command(c, id);
    commands_sent++;
  endtask

  // every reader blocks behind a writer, then one write unlock frees all
  task automatic full_read_phase();
    int ids[MAP_W];
    int j;
    int t;
    foreach (ids[i]) ids[i] = i;
    for (int i = MAP_W - 1; i > 0; i--) begin
      j = $urandom_range(i);
      t = ids[i];
      ids[i] = ids[j];
      ids[j] = t;
    end
    send_command(CMD_WR_LOCK, any_id());
    foreach (ids[i]) send_command(CMD_RD_LOCK, ID_W'(ids[i]));
    send_command(CMD_WR_UNLOCK, any_id());
  endtask

  // fill the writer queue past its depth, then drain part of it
  task automatic writer_pileup();
    repeat (QDEPTH + 2) send_command(CMD_WR_LOCK, any_id());
    repeat ($urandom_range(6, 2)) send_command(CMD_RD_LOCK, any_id());
    repeat (6) begin
      send_command(CMD_WR_UNLOCK, any_id());
      repeat ($urandom_range(3)) send_command(CMD_RD_UNLOCK, any_id());
    end
  endtask

  // readers pile up past the counter range, then drain to let a writer in
  task automatic reader_flood();
    while (tracker.writer_present) send_command(CMD_WR_UNLOCK, any_id());
    repeat (34) send_command(CMD_RD_LOCK, any_id());
    send_command(CMD_WR_LOCK, any_id());
    repeat (3) send_command(CMD_RD_LOCK, any_id());
    repeat (32) send_command(CMD_RD_UNLOCK, any_id());
    send_command(CMD_WR_UNLOCK, any_id());
  endtask

  // main sequence
  initial begin
    int kind;
    int r;
    tracker       = new();
    rst_n         = 1'b0;
    quiet         = 1'b0;
    idle_pct      = 25;
    stall_pct     = 25;
    commands_sent = 0;
    in_ch.valid     <= 1'b0;
    in_ch.command   <= CMD_RD_LOCK;
    in_ch.requester <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: unlock misuse on an idle lock
    send_command(CMD_RD_UNLOCK, 4'd0);
    send_command(CMD_WR_UNLOCK, 4'd15);
    // readers at the id extremes, then a writer that must wait
    send_command(CMD_RD_LOCK, 4'd0);
    send_command(CMD_RD_LOCK, 4'd15);
    send_command(CMD_WR_LOCK, 4'd5);
    // blocked readers, one of them repeated
    send_command(CMD_RD_LOCK, 4'd3);
    send_command(CMD_RD_LOCK, 4'd3);
    send_command(CMD_RD_LOCK, 4'd12);
    send_command(CMD_WR_LOCK, 4'd10);
    // drain readers so the present writer gets the lock
    send_command(CMD_RD_UNLOCK, 4'd0);
    send_command(CMD_RD_UNLOCK, 4'd15);
    // release phase: two readers, then promotion of the queued writer
    send_command(CMD_WR_UNLOCK, 4'd5);
    send_command(CMD_RD_UNLOCK, 4'd3);
    send_command(CMD_RD_UNLOCK, 4'd12);
    send_command(CMD_WR_UNLOCK, 4'd10);
    // idle writer with no readers is granted at once
    send_command(CMD_WR_LOCK, 4'd15);
    send_command(CMD_WR_UNLOCK, 4'd15);
    // extra unlock while free, counter stays at zero
    send_command(CMD_RD_UNLOCK, 4'd7);

    // random part
    reader_flood();
    while (commands_sent < 200) begin
      if (commands_sent >= 160) quiet = 1'b1;
      case ($urandom_range(2))
        0: idle_pct = 0;
        1: idle_pct = 20;
        default: idle_pct = 50;
      endcase
      case ($urandom_range(2))
        0: stall_pct = 0;
        1: stall_pct = 20;
        default: stall_pct = 50;
      endcase
      kind = $urandom_range(99);
      if (kind < 20) begin
        // noise: any command from any id
        repeat (10) send_command(cmd_t'($urandom_range(3)), any_id());
      end else if (kind < 65) begin
        // lock traffic weighted toward reader activity
        repeat (15) begin
          r = $urandom_range(99);
          if (r < 35)
            send_command(CMD_RD_LOCK, any_id());
          else if (r < 55)
            send_command(CMD_WR_LOCK, any_id());
          else if (r < 85)
            send_command(CMD_RD_UNLOCK, any_id());
          else
            send_command(CMD_WR_UNLOCK, any_id());
        end
      end else if (kind < 85) begin
        full_read_phase();
      end else begin
        writer_pileup();
      end
    end

    // wait for outstanding grants, then for any stray ones
    in_ch.valid <= 1'b0;
    while (tracker.pending_grants.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (tracker.mismatches == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
